// File: src/ccn_pkg.sv
// Package for the confirmed client notifier: client phases, table entry type,
// register indexes and sizing constants. No dependencies.
`default_nettype none

package ccn_pkg;

  // Number of client slots (1..8); the table register holds 8 address bytes and the index width is fixed at 3 bits
  localparam int unsigned MaxClients = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned CntW       = 4;

  localparam logic [7:0] AddrInvalid = 8'hFF;

  // Configuration register indexes
  localparam logic [2:0] CfgOwnAddr  = 3'd0;
  localparam logic [2:0] CfgTable    = 3'd1;
  localparam logic [2:0] CfgHold     = 3'd2;
  localparam logic [2:0] CfgTimeout  = 3'd3;
  localparam logic [2:0] CfgRetry    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [7:0]  HoldReset    = 8'd20;
  localparam logic [15:0] TimeoutReset = 16'd100;
  localparam logic [15:0] RetryReset   = 16'd10000;

  typedef enum logic [2:0] {
    PH_INIT = 3'd0,
    PH_SKIP = 3'd1,
    PH_HOLD = 3'd2,
    PH_WAIT = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  // One client entry of the state memory
  typedef struct packed {
    logic [7:0]  addr;
    phase_e      phase;
    logic [15:0] stamp;
  } ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_RELOAD,
    ST_SCAN,
    ST_MSCAN,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// File: src/confirmed_client_notifier_top.sv
// Top level of the confirmed client notifier: sequencer around one client
// entry memory. Depends on ccn_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat per step: mode 0
//   steps the run with the current switch value, mode 1 delivers a received
//   confirmation telegram. Every input beat gives exactly one output beat
//   (out_valid_o / out_stall_i) with the request to send, if any, and the run
//   status. Configuration writes use cfg_valid_i / cfg_ready_o with a register
//   index and 64-bit data; ready is always high, writes must go in while idle (not enforced by the block).
// Sequence:
//   A plain mode 0 step reads its entry (ST_RD), evaluates it (ST_EVAL) and
//   registers its output beat from ST_FIN; the next input beat is taken once
//   the sequencer is back in ST_IDLE. A new run first reloads every table
//   entry, then re-reads the current entry. Moving to the next client is a
//   round-robin scan, 1 entry a cycle; after a confirmed client the new one is
//   re-read and a timeout there scans once more. A mode 1 beat addressed to
//   own_addr scans the memory in order from entry 0. The entry memory has one
//   read and one write address; one beat is worked on at a time.
// Reset:
//   All clients read as skip (per-entry valid bits), no run, thresholds at
//   their defaults. A stalled output holds; one more input beat is taken
//   meanwhile and waits for the output register before finishing.
`default_nettype none

module confirmed_client_notifier_top import ccn_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [63:0]       cfg_data_i,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              mode_i,
  input  wire logic [15:0]       now_ms_i,
  input  wire logic [7:0]        switch_value_i,
  input  wire logic [7:0]        sender_address_i,
  input  wire logic [7:0]        receiver_address_i,
  input  wire logic [7:0]        reply_value_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   send_valid_o,
  output logic [7:0]             send_address_o,
  output logic [7:0]             send_value_o,
  output logic                   run_active_o,
  output logic [2:0]             current_client_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [7:0]  own_addr_q;
  logic [63:0] table_q;
  logic [7:0]  hold_q;
  logic [15:0] timeout_q;
  logic [15:0] retry_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      table_q    <= '1;
      hold_q     <= HoldReset;
      timeout_q  <= TimeoutReset;
      retry_q    <= RetryReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgOwnAddr: own_addr_q <= cfg_data_i[7:0];
        CfgTable:   table_q    <= cfg_data_i;
        CfgHold:    hold_q     <= cfg_data_i[7:0];
        CfgTimeout: timeout_q  <= cfg_data_i[15:0];
        CfgRetry:   retry_q    <= cfg_data_i[15:0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control and run state
  state_e          state_q, state_d;
  logic            active_q, active_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     change_q, change_d;
  logic [7:0]      last_seen_q, last_seen_d;
  logic [7:0]      sent_q, sent_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] iss_q, iss_d;     // entry whose read goes out this cycle
  logic [IdxW-1:0] chk_q, chk_d;     // entry whose read data is in rdata_q
  logic            reeval_q, reeval_d;
  logic            send_q, send_d;
  logic [7:0]      send_addr_q, send_addr_d;
  logic            out_valid_q, out_valid_d;

  // latched input beat
  logic [15:0] in_now_q;
  logic [7:0]  in_sw_q;
  logic [7:0]  in_sender_q;
  logic [7:0]  in_reply_q;

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Client entry memory, registered read, valid bit per entry
  ent_t                  mem_q [MaxClients];
  ent_t                  rdata_q;
  logic                  rd_vld_q;
  logic [MaxClients-1:0] vld_q;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  ent_t                  wdata;
  logic [IdxW-1:0]       raddr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Decisions on the entry in rdata_q
  phase_e      cur_ph;
  logic        ev_start;
  logic        ev_age_ok;
  logic        ev_hold_ok;
  logic        ev_wait_ok;
  logic        sc_check;
  logic        sc_hit;
  logic        sc_end;
  logic        mc_hit;
  logic        out_free;
  logic [15:0] age;
  logic [15:0] wait_age;
  logic [7:0]  hold_age;
  logic [7:0]  tbl_byte;

  assign cur_ph     = rd_vld_q ? rdata_q.phase : PH_SKIP;
  assign ev_start   = (in_sw_q != last_seen_q) && !(active_q && (cur_ph == PH_HOLD));
  assign age        = in_now_q - change_q;
  assign ev_age_ok  = (age < retry_q);
  assign hold_age   = in_now_q[7:0] - rdata_q.stamp[7:0];
  assign ev_hold_ok = (hold_age >= hold_q);
  assign wait_age   = in_now_q - rdata_q.stamp;
  assign ev_wait_ok = (wait_age >= timeout_q);

  // scans: a check is due once a read has been issued
  assign sc_check = (cnt_q != '0);
  assign sc_hit   = sc_check && (cur_ph != PH_SKIP) && (cur_ph != PH_DONE);
  assign sc_end   = (cnt_q == CntW'(MaxClients));
  assign mc_hit   = sc_check && ((cur_ph == PH_HOLD) || (cur_ph == PH_WAIT)) &&
                    (rdata_q.addr == in_sender_q) && (in_reply_q == sent_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign tbl_byte = table_q[8*cnt_q[IdxW-1:0] +: 8];

  // round-robin successor of an entry index
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] n;
    n = (i == IdxW'(MaxClients - 1)) ? '0 : i + IdxW'(1);
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (!mode_i)                          state_d = ST_RD;
          else if (receiver_address_i == own_addr_q)     state_d = ST_MSCAN;
          else                                           state_d = ST_FIN;
        end
      end
      ST_RD: state_d = ST_EVAL;
      ST_EVAL: begin
        priority if (ev_start)           state_d = ST_RELOAD;
        else if (!active_q)              state_d = ST_FIN;
        else if (!ev_age_ok)             state_d = ST_FIN;
        else if (cur_ph == PH_DONE)      state_d = ST_SCAN;
        else if (cur_ph == PH_WAIT && ev_wait_ok) state_d = ST_SCAN;
        else                             state_d = ST_FIN;
      end
      ST_RELOAD: begin
        if (cnt_q == CntW'(MaxClients - 1)) state_d = ST_RD;
      end
      ST_SCAN: begin
        priority if (sc_hit) state_d = reeval_q ? ST_RD : ST_FIN;
        else if (sc_end)     state_d = ST_FIN;
        else                 state_d = ST_SCAN;
      end
      ST_MSCAN: begin
        if (mc_hit || sc_end) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath controls
  always_comb begin
    active_d    = active_q;
    idx_d       = idx_q;
    change_d    = change_q;
    last_seen_d = last_seen_q;
    sent_d      = sent_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    reeval_d    = reeval_q;
    send_d      = send_q;
    send_addr_d = send_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata_q;
    raddr       = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        send_d = 1'b0;
        cnt_d  = '0;
        iss_d  = '0;
      end
      ST_RD: ;
      ST_EVAL: begin
        priority if (ev_start) begin
          last_seen_d = in_sw_q;
          sent_d      = in_sw_q;
          change_d    = in_now_q;
          idx_d       = '0;
          active_d    = 1'b1;
          cnt_d       = '0;
        end else if (!active_q) begin
        end else if (!ev_age_ok) begin
          active_d = 1'b0;
          idx_d    = '0;
        end else if (cur_ph == PH_DONE) begin
          reeval_d = 1'b1;
          cnt_d    = '0;
          iss_d    = next_idx(idx_q);
        end else if (cur_ph == PH_INIT) begin
          send_d       = 1'b1;
          send_addr_d  = rdata_q.addr;
          we           = 1'b1;
          wdata.phase  = PH_HOLD;
          wdata.stamp  = in_now_q;
        end else if (cur_ph == PH_HOLD) begin
          if (ev_hold_ok) begin
            we          = 1'b1;
            wdata.phase = PH_WAIT;
            wdata.stamp = in_now_q;
          end
        end else if (cur_ph == PH_WAIT) begin
          if (ev_wait_ok) begin
            we          = 1'b1;
            wdata.phase = PH_INIT;
            reeval_d    = 1'b0;
            cnt_d       = '0;
            iss_d       = next_idx(idx_q);
          end
        end else begin
        end
      end
      ST_RELOAD: begin
        we          = 1'b1;
        waddr       = cnt_q[IdxW-1:0];
        wdata.addr  = tbl_byte;
        wdata.phase = (tbl_byte != AddrInvalid) ? PH_INIT : PH_SKIP;
        wdata.stamp = in_now_q;
        cnt_d       = cnt_q + CntW'(1);
      end
      ST_SCAN: begin
        raddr = iss_q;
        iss_d = next_idx(iss_q);
        chk_d = iss_q;
        cnt_d = cnt_q + CntW'(1);
        priority if (sc_hit) begin
          idx_d = chk_q;
        end else if (sc_end) begin
          active_d = 1'b0;
          idx_d    = '0;
        end else begin
        end
      end
      ST_MSCAN: begin
        raddr = iss_q;
        iss_d = next_idx(iss_q);
        chk_d = iss_q;
        cnt_d = cnt_q + CntW'(1);
        if (mc_hit) begin
          we          = 1'b1;
          waddr       = chk_q;
          wdata.phase = PH_DONE;
        end
      end
      ST_FIN: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      idx_q       <= '0;
      change_q    <= '0;
      last_seen_q <= 8'hFF;
      sent_q      <= '0;
      cnt_q       <= '0;
      iss_q       <= '0;
      chk_q       <= '0;
      reeval_q    <= 1'b0;
      send_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      idx_q       <= idx_d;
      change_q    <= change_d;
      last_seen_q <= last_seen_d;
      sent_q      <= sent_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      chk_q       <= chk_d;
      reeval_q    <= reeval_d;
      send_q      <= send_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: input beat and output beat
  always_ff @(posedge clk_i) begin
    send_addr_q <= send_addr_d;
    if (in_acc) begin
      in_now_q    <= now_ms_i;
      in_sw_q     <= switch_value_i;
      in_sender_q <= sender_address_i;
      in_reply_q  <= reply_value_i;
    end
    if (state_q == ST_FIN && out_free) begin
      send_valid_o     <= send_q;
      send_address_o   <= send_q ? send_addr_q : 8'h00;
      send_value_o     <= send_q ? sent_q : 8'h00;
      run_active_o     <= active_q;
      current_client_o <= active_q ? idx_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/ccn_checker.sv
// Port-level checker for the confirmed client notifier, bound to the top level.
// Depends on confirmed_client_notifier_top's port names.
`default_nettype none

module ccn_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       send_valid_o,
  input wire logic [7:0] send_address_o,
  input wire logic [7:0] send_value_o,
  input wire logic       run_active_o,
  input wire logic [2:0] current_client_o
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(send_valid_o) &&
    $stable(send_address_o) && $stable(send_value_o))
    else $error("output beat changed while stalled");

  // no run, no client index
  a_idle_client: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_active_o |-> current_client_o == 3'd0)
    else $error("client index set without a run");

  // no request, zero payload
  a_no_send_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |-> send_address_o == 8'h00 && send_value_o == 8'h00)
    else $error("request fields set without a request");

  // a request is only sent within a run
  a_send_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> run_active_o)
    else $error("request sent outside a run");

endmodule

bind confirmed_client_notifier_top ccn_checker u_ccn_checker (.*);

`default_nettype wire

// File: dv/confirmed_client_notifier_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for confirmed_client_notifier_top: drives steps and confirmations
// with random idling and compares every output beat with a predictor of the run.
// Depends on ccn_pkg and the RTL of confirmed_client_notifier_top.

import ccn_pkg::*;

// One input beat
typedef struct {
  logic        mode;
  logic [15:0] now_ms;
  logic [7:0]  switch_value;
  logic [7:0]  sender_address;
  logic [7:0]  receiver_address;
  logic [7:0]  reply_value;
} step_t;

// One output beat
typedef struct {
  logic       send_valid;
  logic [7:0] send_address;
  logic [7:0] send_value;
  logic       run_active;
  logic [2:0] current_client;
} notice_t;

// Predicts the notice for each accepted step and checks the notices that come out
class notice_tracker;
  logic [7:0]  own_addr;
  logic [63:0] addr_table;
  logic [7:0]  hold_ms;
  logic [15:0] timeout_ms;
  logic [15:0] retry_ms;

  logic [7:0]  addr_copy [MaxClients];
  phase_e      phase [MaxClients];
  logic [15:0] stamp [MaxClients];
  logic [2:0]  cur;
  bit          running;
  logic [15:0] change_at;
  logic [7:0]  last_seen;
  logic [7:0]  value_sent;

  notice_t     due_notices[$];
  int          mismatches;

  function new();
    own_addr   = 8'd0;
    addr_table = '1;
    hold_ms    = HoldReset;
    timeout_ms = TimeoutReset;
    retry_ms   = RetryReset;
    for (int i = 0; i < MaxClients; i++) begin
      addr_copy[i] = 8'd0;
      phase[i]     = PH_SKIP;
      stamp[i]     = 16'd0;
    end
    cur        = 3'd0;
    running    = 1'b0;
    change_at  = 16'd0;
    last_seen  = 8'hFF;
    value_sent = 8'd0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      CfgOwnAddr: own_addr   = data[7:0];
      CfgTable:   addr_table = data;
      CfgHold:    hold_ms    = data[7:0];
      CfgTimeout: timeout_ms = data[15:0];
      CfgRetry:   retry_ms   = data[15:0];
      default: ;
    endcase
  endfunction

  // Round-robin search for the next client that still needs serving
  function void move_on();
    int n;
    for (int k = 1; k <= MaxClients; k++) begin
      n = (int'(cur) + k) % MaxClients;
      if (phase[n] != PH_SKIP && phase[n] != PH_DONE) begin
        cur = 3'(n);
        return;
      end
    end
    running = 1'b0;
    cur     = 3'd0;
  endfunction

  // Note an accepted step and queue the notice it must produce
  function void take_step(step_t s);
    notice_t     r;
    logic [7:0]  a;
    logic [7:0]  low_diff;
    logic [15:0] diff;
    int          c;
    r = '{default: '0};
    if (!s.mode) begin
      // a change restarts the run unless the current client is in its hold window
      if (s.switch_value != last_seen && !(running && phase[cur] == PH_HOLD)) begin
        last_seen  = s.switch_value;
        value_sent = s.switch_value;
        change_at  = s.now_ms;
        cur        = 3'd0;
        running    = 1'b1;
        for (int i = 0; i < MaxClients; i++) begin
          a            = addr_table[8*i +: 8];
          addr_copy[i] = a;
          if (a != AddrInvalid) phase[i] = PH_INIT;
          else phase[i] = PH_SKIP;
        end
      end
      if (running) begin
        diff = s.now_ms - change_at;
        if (diff < retry_ms) begin
          if (phase[cur] == PH_DONE) move_on();
          if (running) begin
            c = cur;
            case (phase[c])
              PH_INIT: begin
                r.send_valid   = 1'b1;
                r.send_address = addr_copy[c];
                r.send_value   = value_sent;
                phase[c]       = PH_HOLD;
                stamp[c]       = s.now_ms;
              end
              PH_HOLD: begin
                low_diff = s.now_ms[7:0] - stamp[c][7:0];
                if (low_diff >= hold_ms) begin
                  phase[c] = PH_WAIT;
                  stamp[c] = s.now_ms;
                end
              end
              PH_WAIT: begin
                diff = s.now_ms - stamp[c];
                if (diff >= timeout_ms) begin
                  phase[c] = PH_INIT;
                  move_on();
                end
              end
              default: ;
            endcase
          end
        end else begin
          running = 1'b0;
          cur     = 3'd0;
        end
      end
    end else if (s.receiver_address == own_addr) begin
      // first pending client with matching address and echoed value is confirmed
      for (int i = 0; i < MaxClients; i++) begin
        if (phase[i] != PH_SKIP && addr_copy[i] == s.sender_address &&
            s.reply_value == value_sent && (phase[i] == PH_HOLD || phase[i] == PH_WAIT)) begin
          phase[i] = PH_DONE;
          break;
        end
      end
    end
    r.run_active     = running;
    r.current_client = running ? cur : 3'd0;
    due_notices.push_back(r);
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void match_notice(notice_t got);
    notice_t want;
    if (due_notices.size() == 0) begin
      $error("output beat with no step pending");
      mismatches++;
      return;
    end
    want = due_notices.pop_front();
    compare_field("send_valid", want.send_valid, got.send_valid);
    compare_field("send_address", want.send_address, got.send_address);
    compare_field("send_value", want.send_value, got.send_value);
    compare_field("run_active", want.run_active, got.run_active);
    compare_field("current_client", want.current_client, got.current_client);
  endfunction
endclass

module confirmed_client_notifier_top_test;
  localparam int ClkPeriod   = 8;
  localparam int ResetCycles = 11;
  localparam int DrainCycles = 32;
  localparam int LimitCycles = 500000;
  // indexes outside the register list
  localparam logic [2:0] CfgSpareLo = 3'd5;
  localparam logic [2:0] CfgSpareHi = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        mode_i;
  logic [15:0] now_ms_i;
  logic [7:0]  switch_value_i;
  logic [7:0]  sender_address_i;
  logic [7:0]  receiver_address_i;
  logic [7:0]  reply_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        send_valid_o;
  logic [7:0]  send_address_o;
  logic [7:0]  send_value_o;
  logic        run_active_o;
  logic [2:0]  current_client_o;

  notice_tracker notes;
  int          tx_burst;
  int          rx_burst;
  int          long_hold;
  logic [15:0] clock_ms;
  logic [7:0]  switch_now;

  confirmed_client_notifier_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .now_ms_i           (now_ms_i),
    .switch_value_i     (switch_value_i),
    .sender_address_i   (sender_address_i),
    .receiver_address_i (receiver_address_i),
    .reply_value_i      (reply_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .send_valid_o       (send_valid_o),
    .send_address_o     (send_address_o),
    .send_value_o       (send_value_o),
    .run_active_o       (run_active_o),
    .current_client_o   (current_client_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Idle cycles before the next beat; now and then a run of back-to-back beats
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Register value with random junk above its width
  function automatic logic [63:0] padded(logic [63:0] v, int width);
    logic [63:0] mask;
    mask = (64'd1 << width) - 64'd1;
    return ({$urandom, $urandom} & ~mask) | (v & mask);
  endfunction

  // Address table: invalid entries at roughly 1 in odds, small addresses often repeat
  function automatic logic [63:0] random_table(int odds);
    logic [63:0] tbl;
    for (int i = 0; i < MaxClients; i++) begin
      if ($urandom_range(1, odds) == 1) tbl[8*i +: 8] = AddrInvalid;
      else if ($urandom_range(0, 3) == 0) tbl[8*i +: 8] = 8'($urandom_range(0, 3));
      else tbl[8*i +: 8] = 8'($urandom_range(0, 254));
    end
    return tbl;
  endfunction

  task automatic put_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    notes.write_reg(idx, data);
  endtask

  task automatic load_setting(input logic [7:0] own, input logic [63:0] tbl,
                              input logic [7:0] hold, input logic [15:0] tmo,
                              input logic [15:0] retry);
    put_reg(CfgOwnAddr, padded(own, 8));
    put_reg(CfgTable, tbl);
    put_reg(CfgHold, padded(hold, 8));
    put_reg(CfgTimeout, padded(tmo, 16));
    put_reg(CfgRetry, padded(retry, 16));
    put_reg(3'($urandom_range(CfgSpareLo, CfgSpareHi)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input step_t s);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    mode_i             <= s.mode;
    now_ms_i           <= s.now_ms;
    switch_value_i     <= s.switch_value;
    sender_address_i   <= s.sender_address;
    receiver_address_i <= s.receiver_address;
    reply_value_i      <= s.reply_value;
    do @(posedge clk_i); while (in_stall_o);
    notes.take_step(s);
  endtask

  task automatic do_tick(input logic [15:0] t, input logic [7:0] sw);
    step_t s;
    s.mode             = 1'b0;
    s.now_ms           = t;
    s.switch_value     = sw;
    s.sender_address   = 8'($urandom);
    s.receiver_address = 8'($urandom);
    s.reply_value      = 8'($urandom);
    send_item(s);
  endtask

  task automatic do_confirm(input logic [7:0] from, input logic [7:0] to,
                            input logic [7:0] val);
    step_t s;
    s.mode             = 1'b1;
    s.now_ms           = 16'($urandom);
    s.switch_value     = 8'($urandom);
    s.sender_address   = from;
    s.receiver_address = to;
    s.reply_value      = val;
    send_item(s);
  endtask

  // Wait until every notice is in and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (notes.due_notices.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly time steps and proper confirmations, some broken ones and noise
  task automatic random_items(input int count);
    step_t s;
    int    pick;
    int    r;
    int    dt;
    int    idx;
    repeat (count) begin
      pick               = $urandom_range(0, 99);
      s.mode             = 1'($urandom);
      s.now_ms           = 16'($urandom);
      s.switch_value     = 8'($urandom);
      s.sender_address   = 8'($urandom);
      s.receiver_address = 8'($urandom);
      s.reply_value      = 8'($urandom);
      if (pick < 55) begin
        r = $urandom_range(0, 19);
        if (r < 12) dt = $urandom_range(0, 30);
        else if (r < 17) dt = $urandom_range(30, 160);
        else if (r < 19) dt = $urandom_range(160, 2000);
        else dt = $urandom_range(0, 65535);
        clock_ms = clock_ms + 16'(dt);
        if ($urandom_range(0, 7) == 0) switch_now = 8'($urandom);
        s.mode         = 1'b0;
        s.now_ms       = clock_ms;
        s.switch_value = switch_now;
      end else if (pick < 88) begin
        if (notes.running && $urandom_range(0, 2) != 0) idx = notes.cur;
        else idx = $urandom_range(0, MaxClients - 1);
        s.mode             = 1'b1;
        s.now_ms           = clock_ms;
        s.sender_address   = notes.addr_copy[idx];
        s.receiver_address = notes.own_addr;
        s.reply_value      = notes.value_sent;
        case ($urandom_range(0, 9))
          0: s.sender_address = 8'($urandom);
          1: s.receiver_address = 8'($urandom);
          2: s.reply_value = 8'($urandom);
          default: ;
        endcase
      end else if (!s.mode) begin
        clock_ms = s.now_ms;
      end
      send_item(s);
    end
  endtask

  task automatic run_phase(input logic [7:0] own, input logic [63:0] tbl,
                           input logic [7:0] hold, input logic [15:0] tmo,
                           input logic [15:0] retry, input int count, input int hold_off);
    settle();
    load_setting(own, tbl, hold, tmo, retry);
    long_hold = hold_off;
    random_items(count);
  endtask

  // Output side: random stalls, one long hold-off on request
  initial begin : notice_sink
    notice_t got;
    int      wait_n;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold > 0) begin
        wait_n    = long_hold;
        long_hold = 0;
      end else begin
        wait_n = draw_gap(rx_burst);
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.send_valid     = send_valid_o;
      got.send_address   = send_address_o;
      got.send_value     = send_value_o;
      got.run_active     = run_active_o;
      got.current_client = current_client_o;
      notes.match_notice(got);
    end
  end

  initial begin : watchdog
    #(LimitCycles * ClkPeriod);
    $display("confirmed_client_notifier_top test failed");
    $finish;
  end

  initial begin : stimulus
    notes     = new();
    tx_burst  = 0;
    rx_burst  = 0;
    long_hold = 0;
    rst_ni             <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_index_i        <= CfgOwnAddr;
    cfg_data_i         <= 64'd0;
    in_valid_i         <= 1'b0;
    mode_i             <= 1'b0;
    now_ms_i           <= 16'd0;
    switch_value_i     <= 8'd0;
    sender_address_i   <= 8'd0;
    receiver_address_i <= 8'd0;
    reply_value_i      <= 8'd0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: every client invalid
    do_tick(16'd0, 8'hFF);             // no change from the reset value
    do_confirm(8'h00, 8'h00, 8'h00);   // nobody pending
    do_tick(16'd5, 8'h00);             // run over an all-skip table
    settle();

    // Clients 0 and 3 share address 0x00, client 2 is 0xFE, the rest invalid
    load_setting(8'hA5, 64'hFFFF_FFFF_00FE_FF00, 8'd20, 16'd100, 16'd10000);
    do_tick(16'd65500, 8'h3C);         // new run, request to client 0
    do_tick(16'd65505, 8'h81);         // change deferred in hold
    do_tick(16'd65530, 8'h81);         // still deferred, hold passes
    do_tick(16'd65535, 8'h81);         // restart from wait
    do_tick(16'd20, 8'h81);            // hold passes across the time wrap
    do_confirm(8'h00, 8'hA5, 8'h81);   // client 0 confirmed
    do_confirm(8'h00, 8'hA5, 8'h81);   // repeat has no target
    do_tick(16'd21, 8'h81);            // skip over invalid client 1, request client 2
    do_confirm(8'hFE, 8'h5A, 8'h81);   // wrong receiver
    do_confirm(8'hFE, 8'hA5, 8'h7E);   // wrong echoed value
    do_tick(16'd45, 8'h81);            // into wait
    do_tick(16'd145, 8'h81);           // response timeout, on to client 3
    do_tick(16'd146, 8'h81);           // request client 3
    do_confirm(8'h00, 8'hA5, 8'h81);   // duplicate address: client 3 matches
    do_tick(16'd147, 8'h81);           // round-robin back to client 2
    do_confirm(8'hFE, 8'hA5, 8'h81);
    do_tick(16'd150, 8'h81);           // nobody left, run ends
    do_tick(16'd200, 8'h00);           // new run
    do_tick(16'd10200, 8'h00);         // retry limit reached, run dropped
    do_confirm(8'hFF, 8'hFF, 8'hFF);

    clock_ms   = 16'd10200;
    switch_now = 8'h00;
    run_phase(8'h00, random_table(4), 8'd20, 16'd100, 16'd10000, 110, 0);
    // zero hold and timeout, longest retry
    run_phase(8'hFF, random_table(64), 8'd0, 16'd0, 16'hFFFF, 90, 0);
    // longest hold and timeout, zero retry drops every run
    run_phase(8'($urandom), random_table(2), 8'hFF, 16'hFFFF, 16'd0, 40, 0);
    // output held off long enough to back up the input
    run_phase(8'($urandom), random_table(4), 8'($urandom_range(0, 40)),
              16'($urandom_range(20, 300)), 16'($urandom_range(200, 3000)), 100, 300);
    run_phase(8'($urandom), random_table(3), 8'($urandom), 16'($urandom),
              16'($urandom), 90, 0);
    run_phase(8'($urandom), 64'd0, 8'd1, 16'd1, 16'hFFFF, 90, 0);
    settle();

    if (notes.mismatches == 0) begin
      $display("confirmed_client_notifier_top test passed");
    end else begin
      $display("confirmed_client_notifier_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/ccn_pkg.sv
src/confirmed_client_notifier_top.sv
src/ccn_checker.sv
dv/confirmed_client_notifier_top_test.sv
